>>> hw/rtl/fire_effect_propagator_macros.svh
// ----------------------------------------------------------------------------
// Fire effect propagator assertion macros
// Shared concurrent assertion forms, clocked on clk and held off during rst.
// ----------------------------------------------------------------------------
`ifndef FIRE_EFFECT_PROPAGATOR_MACROS_SVH
`define FIRE_EFFECT_PROPAGATOR_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define FEP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define FEP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> hw/rtl/fep_pkg.sv
// ----------------------------------------------------------------------------
// fep_pkg
// Types and constants shared by the fire effect propagator modules.
// ----------------------------------------------------------------------------
package fep_pkg;

  localparam int PIXEL_W      = 8;
  localparam int NEW_W        = 7;
  localparam int COLUMN_W     = 6;
  localparam int ROW_W        = 7;
  localparam int WIDTH_REG_W  = 7;
  localparam int HEIGHT_REG_W = 8;
  localparam int CFG_DATA_W   = 8;
  localparam int CFG_INDEX_W  = 1;

  localparam logic [CFG_INDEX_W-1:0] CFG_WINDOW_WIDTH  = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_WINDOW_HEIGHT = 1'd1;

  localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 7'd32;
  localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 8'd128;

  // sum of four pixels, then floor(sum * 80 / 321) as (sum * RECIP) >> RECIP_SHIFT
  localparam int SUM_W       = 10;
  localparam int RECIP_W     = 18;
  localparam int RECIP_SHIFT = 20;
  localparam logic [RECIP_W-1:0] RECIP = 18'd261328;

  localparam int QUEUE_DEPTH   = 4;
  localparam int QUEUE_PTR_W   = 2;
  localparam int QUEUE_COUNT_W = 3;

  typedef struct packed {
    logic [PIXEL_W-1:0] old_pixel;
    logic               frame_start;
  } pixel_t;

  typedef struct packed {
    logic [NEW_W-1:0]    new_pixel;
    logic [COLUMN_W-1:0] column;
    logic [ROW_W-1:0]    row;
    logic                frame_last;
  } result_t;

  typedef struct packed {
    logic [SUM_W-1:0]    sum;
    logic [COLUMN_W-1:0] column;
    logic [ROW_W-1:0]    row;
    logic                frame_last;
  } work_t;

  typedef struct packed {
    logic [PIXEL_W-1:0] two_below;
    logic [PIXEL_W-1:0] below;
  } line_t;

endpackage

>>> hw/rtl/fep_front.sv
// ----------------------------------------------------------------------------
// fep_front
// Accepts old pixels, tracks row and column, keeps the two line stores and
// forms the neighbourhood sum for each interior pixel of an output row.
// ----------------------------------------------------------------------------
module fep_front #(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 128
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [fep_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [fep_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                               pixel_valid,
  output logic                               pixel_ready,
  input  fep_pkg::pixel_t                    pixel,
  input  logic [fep_pkg::QUEUE_COUNT_W-1:0]  queue_count,
  output logic                               push,
  output fep_pkg::work_t                     push_data
);

  `include "fire_effect_propagator_macros.svh"

  localparam int LINE_DEPTH = MAX_WIDTH + 2;
  localparam int ADDR_W     = $clog2(LINE_DEPTH);
  localparam int COL_W      = $clog2(MAX_WIDTH + 3);
  localparam int ROWC_W     = $clog2(MAX_HEIGHT + 2);
  localparam int WCMP_W     = (COL_W > fep_pkg::WIDTH_REG_W) ? COL_W : fep_pkg::WIDTH_REG_W;
  localparam int HCMP_W     = (ROWC_W > fep_pkg::HEIGHT_REG_W) ? ROWC_W : fep_pkg::HEIGHT_REG_W;
  localparam int CO_W       = (COL_W > fep_pkg::COLUMN_W) ? COL_W : fep_pkg::COLUMN_W;
  localparam int RO_W       = (ROWC_W > fep_pkg::ROW_W) ? ROWC_W : fep_pkg::ROW_W;

  logic [fep_pkg::WIDTH_REG_W-1:0]  window_width;
  logic [fep_pkg::HEIGHT_REG_W-1:0] window_height;

  logic [WCMP_W-1:0] width_ext;
  logic [HCMP_W-1:0] height_ext;
  logic [COL_W-1:0]  eff_w;
  logic [COL_W-1:0]  w_plus1;
  logic [ROWC_W-1:0] eff_h;
  logic [ROWC_W-1:0] h_plus1;

  logic [COL_W-1:0]  column_count;
  logic [ROWC_W-1:0] row_count;

  logic              accept;
  logic [COL_W-1:0]  cur_c;
  logic [ROWC_W-1:0] cur_r;
  logic              row_end;
  logic              emit;
  logic              last;
  logic [CO_W-1:0]   col_diff;
  logic [RO_W-1:0]   row_diff;
  logic [COL_W-1:0]  rd_addr;
  logic [ADDR_W-1:0] rd_idx;
  logic              rd_en;

  logic                               b_valid;
  logic [COL_W-1:0]                   b_c;
  logic [fep_pkg::PIXEL_W-1:0]        b_pix;
  logic                               b_emit;
  logic                               b_row_end;
  logic [fep_pkg::COLUMN_W-1:0]       b_column;
  logic [fep_pkg::ROW_W-1:0]          b_row;
  logic                               b_last;
  logic [COL_W-1:0]                   b_c_dec;
  logic                               b_wr;

  logic [fep_pkg::PIXEL_W-1:0] hold_pixel;
  logic [fep_pkg::PIXEL_W-1:0] below0;
  logic [fep_pkg::PIXEL_W-1:0] win_m1;
  logic [fep_pkg::PIXEL_W-1:0] win_0;
  logic [fep_pkg::PIXEL_W-1:0] win_tb;
  logic [fep_pkg::PIXEL_W-1:0] eff_0;

  logic                  pend_valid;
  logic [ADDR_W-1:0]     pend_addr;
  fep_pkg::line_t        pend_data;

  fep_pkg::line_t        line_mem [LINE_DEPTH];
  logic [LINE_DEPTH-1:0] line_valid;
  fep_pkg::line_t        rd_line;
  logic                  mem_we;
  logic [ADDR_W-1:0]     mem_wa;
  fep_pkg::line_t        mem_wd;

  // clamp the window registers
  always_comb begin
    width_ext  = WCMP_W'(window_width);
    height_ext = HCMP_W'(window_height);
    if (width_ext == '0) begin
      eff_w = COL_W'(1);
    end else if (width_ext > WCMP_W'(MAX_WIDTH)) begin
      eff_w = COL_W'(MAX_WIDTH);
    end else begin
      eff_w = COL_W'(width_ext);
    end
    if (height_ext == '0) begin
      eff_h = ROWC_W'(1);
    end else if (height_ext > HCMP_W'(MAX_HEIGHT)) begin
      eff_h = ROWC_W'(MAX_HEIGHT);
    end else begin
      eff_h = ROWC_W'(height_ext);
    end
    w_plus1 = eff_w + COL_W'(1);
    h_plus1 = eff_h + ROWC_W'(1);
  end

  // classify the incoming pixel
  assign accept = pixel_valid & pixel_ready;

  always_comb begin
    cur_c    = pixel.frame_start ? '0 : column_count;
    cur_r    = pixel.frame_start ? '0 : row_count;
    row_end  = (cur_c >= w_plus1);
    emit     = (cur_r >= ROWC_W'(2)) && (cur_r <= h_plus1) &&
               (cur_c >= COL_W'(1)) && (cur_c <= eff_w);
    last     = (cur_r == h_plus1) && (cur_c == eff_w);
    col_diff = CO_W'(cur_c) - CO_W'(1);
    row_diff = RO_W'(h_plus1) - RO_W'(cur_r);
    rd_addr  = cur_c + COL_W'(1);
    rd_idx   = rd_addr[ADDR_W-1:0];
    rd_en    = accept && (rd_addr < COL_W'(LINE_DEPTH));
  end

  assign pixel_ready = (queue_count + fep_pkg::QUEUE_COUNT_W'(b_valid))
                       < fep_pkg::QUEUE_COUNT_W'(fep_pkg::QUEUE_DEPTH);

  // line store access from the second stage
  assign b_c_dec = b_c - COL_W'(1);
  assign b_wr    = b_valid && (b_c != '0);
  assign eff_0   = (b_c == '0) ? below0 : win_0;

  always_comb begin
    mem_we = b_wr || pend_valid;
    if (pend_valid) begin
      mem_wa = pend_addr;
      mem_wd = pend_data;
    end else begin
      mem_wa           = b_c_dec[ADDR_W-1:0];
      mem_wd.two_below = win_m1;
      mem_wd.below     = hold_pixel;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      line_mem[mem_wa] <= mem_wd;
    end
    if (rd_en) begin
      if (mem_we && (mem_wa == rd_idx)) begin
        rd_line <= mem_wd;
      end else if (line_valid[rd_idx]) begin
        rd_line <= line_mem[rd_idx];
      end else begin
        rd_line <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_valid <= '0;
    end else if (mem_we) begin
      line_valid[mem_wa] <= 1'b1;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      window_width  <= fep_pkg::WIDTH_RESET;
      window_height <= fep_pkg::HEIGHT_RESET;
      column_count  <= '0;
      row_count     <= '0;
      b_valid       <= 1'b0;
      pend_valid    <= 1'b0;
      hold_pixel    <= '0;
      below0        <= '0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          fep_pkg::CFG_WINDOW_WIDTH: begin
            window_width <= cfg_data[fep_pkg::WIDTH_REG_W-1:0];
          end
          fep_pkg::CFG_WINDOW_HEIGHT: begin
            window_height <= cfg_data[fep_pkg::HEIGHT_REG_W-1:0];
          end
          default: begin
          end
        endcase
      end
      if (accept) begin
        if (row_end) begin
          column_count <= '0;
          row_count    <= (cur_r >= h_plus1) ? '0 : cur_r + ROWC_W'(1);
        end else begin
          column_count <= cur_c + COL_W'(1);
          row_count    <= cur_r;
        end
      end
      b_valid    <= accept;
      pend_valid <= b_valid && b_row_end;
      if (b_valid) begin
        hold_pixel <= b_pix;
      end
      if (b_wr && (b_c == COL_W'(1))) begin
        below0 <= hold_pixel;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (accept) begin
      b_c       <= cur_c;
      b_pix     <= pixel.old_pixel;
      b_emit    <= emit;
      b_row_end <= row_end;
      b_column  <= col_diff[fep_pkg::COLUMN_W-1:0];
      b_row     <= row_diff[fep_pkg::ROW_W-1:0];
      b_last    <= last;
    end
    if (b_valid && b_row_end) begin
      pend_addr           <= b_c[ADDR_W-1:0];
      pend_data.two_below <= win_0;
      pend_data.below     <= b_pix;
    end
    if (b_valid) begin
      win_m1 <= eff_0;
      win_0  <= rd_line.below;
      win_tb <= rd_line.two_below;
    end
  end

  assign push                 = b_valid && b_emit;
  assign push_data.sum        = fep_pkg::SUM_W'(win_m1) + fep_pkg::SUM_W'(eff_0)
                              + fep_pkg::SUM_W'(rd_line.below) + fep_pkg::SUM_W'(win_tb);
  assign push_data.column     = b_column;
  assign push_data.row        = b_row;
  assign push_data.frame_last = b_last;

  `FEP_ASSERT_NOW(a_one_line_write, pend_valid, !b_wr, "row end write collides with column write")
  `FEP_ASSERT_NOW(a_queue_room, push, queue_count < fep_pkg::QUEUE_COUNT_W'(fep_pkg::QUEUE_DEPTH), "push into full queue")
  `FEP_ASSERT_NEXT(a_pend_single, pend_valid, !pend_valid, "row end write held for two cycles")

endmodule

>>> hw/rtl/fep_queue.sv
// ----------------------------------------------------------------------------
// fep_queue
// Short work queue between the pixel front end and the result back end.
// ----------------------------------------------------------------------------
module fep_queue (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               push,
  input  fep_pkg::work_t                     push_data,
  input  logic                               pop,
  output logic                               head_valid,
  output fep_pkg::work_t                     head,
  output logic [fep_pkg::QUEUE_COUNT_W-1:0]  count
);

  `include "fire_effect_propagator_macros.svh"

  fep_pkg::work_t                   slots [fep_pkg::QUEUE_DEPTH];
  logic [fep_pkg::QUEUE_PTR_W-1:0]  wr_ptr;
  logic [fep_pkg::QUEUE_PTR_W-1:0]  rd_ptr;

  assign head_valid = (count != '0);
  assign head       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + fep_pkg::QUEUE_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + fep_pkg::QUEUE_PTR_W'(1);
      end
      count <= count + fep_pkg::QUEUE_COUNT_W'(push) - fep_pkg::QUEUE_COUNT_W'(pop);
    end
  end

  `FEP_ASSERT_NOW(a_no_overflow, push, count != fep_pkg::QUEUE_COUNT_W'(fep_pkg::QUEUE_DEPTH), "queue overflow")
  `FEP_ASSERT_NOW(a_no_underflow, pop, count != '0, "queue underflow")

endmodule

>>> hw/rtl/fep_back.sv
// ----------------------------------------------------------------------------
// fep_back
// Scales the neighbourhood sum by 80/321 and holds the result for the sink.
// ----------------------------------------------------------------------------
module fep_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              head_valid,
  input  fep_pkg::work_t    head,
  output logic              pop,
  output logic              result_valid,
  input  logic              result_ready,
  output fep_pkg::result_t  result
);

  localparam int PROD_W = fep_pkg::SUM_W + fep_pkg::RECIP_W;

  logic              load;
  logic [PROD_W-1:0] product;

  assign load    = head_valid && (!result_valid || result_ready);
  assign pop     = load;
  assign product = PROD_W'(head.sum) * PROD_W'(fep_pkg::RECIP);

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result.new_pixel  <= product[fep_pkg::RECIP_SHIFT +: fep_pkg::NEW_W];
      result.column     <= head.column;
      result.row        <= head.row;
      result.frame_last <= head.frame_last;
    end
  end

endmodule

>>> hw/rtl/fire_effect_propagator.sv
// ----------------------------------------------------------------------------
// fire_effect_propagator
// Recomputes one frame of a fire window from a bottom-up stream of old pixels.
// ----------------------------------------------------------------------------
// Takes one old pixel per clock while input is not held off. Each frame is window_height + 2 rows of
// window_width + 2 pixels, bottom row first; the two bottom rows and the
// margin columns give no result. Each result passes from the stage after the
// input through a four-entry work queue to the output register; the queue lets
// pixels keep flowing while the sink stalls, and input is held off only once
// that queue, counting the pixel in the stage just after the input, holds four
// entries. The line stores are cleared at reset by per-entry valid bits, so
// the block is ready as soon as reset is released.
module fire_effect_propagator #(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 128
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [fep_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [fep_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                             pixel_valid,
  output logic                             pixel_ready,
  input  fep_pkg::pixel_t                  pixel,
  output logic                             result_valid,
  input  logic                             result_ready,
  output fep_pkg::result_t                 result
);

  logic                               push;
  fep_pkg::work_t                     push_data;
  logic                               pop;
  logic                               head_valid;
  fep_pkg::work_t                     head;
  logic [fep_pkg::QUEUE_COUNT_W-1:0]  queue_count;

  fep_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .pixel_valid (pixel_valid),
    .pixel_ready (pixel_ready),
    .pixel       (pixel),
    .queue_count (queue_count),
    .push        (push),
    .push_data   (push_data)
  );

  fep_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (push_data),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head),
    .count      (queue_count)
  );

  fep_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head_valid   (head_valid),
    .head         (head),
    .pop          (pop),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

>>> verif/fire_effect_propagator_checker.sv
// ----------------------------------------------------------------------------
// fire_effect_propagator_checker
// Watches the pixel, result and register ports of the fire propagator, keeps
// its own copy of the two line stores, the row and column position and the
// window size, works out every new pixel that an accepted old pixel yields and
// compares each accepted result with the oldest one still outstanding.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module fire_effect_propagator_checker
  import fep_pkg::*;
#(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 128
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   pixel_valid,
  input  logic                   pixel_ready,
  input  pixel_t                 pixel,
  input  logic                   result_valid,
  input  logic                   result_ready,
  input  result_t                result,
  output int                     fail_count,
  output int                     pending_count
);

  localparam int LINE_DEPTH = MAX_WIDTH + 2;

  logic [PIXEL_W-1:0]      line_below     [LINE_DEPTH];
  logic [PIXEL_W-1:0]      line_two_below [LINE_DEPTH];
  logic [31:0]             col_pos;
  logic [31:0]             row_pos;
  logic [PIXEL_W-1:0]      held_pixel;
  logic [WIDTH_REG_W-1:0]  width_reg;
  logic [HEIGHT_REG_W-1:0] height_reg;
  result_t                 expected_heat [$];

  initial begin
    fail_count    = 0;
    pending_count = 0;
  end

  task automatic flag_mismatch(input string what);
    $display("%0t ns mismatch: %s", $time, what);
    fail_count++;
  endtask

  task automatic shift_column(input logic [31:0] idx, input logic [PIXEL_W-1:0] value);
    if (idx < LINE_DEPTH) begin
      line_two_below[idx] = line_below[idx];
      line_below[idx]     = value;
    end
  endtask

  task automatic propagate_pixel(input pixel_t item);
    logic [31:0] wd;
    logic [31:0] ht;
    logic [31:0] col;
    logic [31:0] rw;
    logic [31:0] heat;
    logic [31:0] scaled;
    logic [31:0] level;
    result_t     want;
    wd = (width_reg == 0) ? 32'd1 : (width_reg > MAX_WIDTH) ? 32'(MAX_WIDTH) : 32'(width_reg);
    ht = (height_reg == 0) ? 32'd1 :
         (height_reg > MAX_HEIGHT) ? 32'(MAX_HEIGHT) : 32'(height_reg);
    if (item.frame_start) begin
      col_pos = 0;
      row_pos = 0;
    end
    col = col_pos;
    rw  = row_pos;
    if (rw >= 2 && rw <= ht + 1 && col >= 1 && col <= wd && col + 1 < LINE_DEPTH) begin
      heat   = line_below[col - 1] + line_below[col] + line_below[col + 1]
             + line_two_below[col];
      scaled = (heat * 80) / 321;
      level  = ht + 1 - rw;
      want.new_pixel  = scaled[NEW_W-1:0];
      want.column     = 6'(col - 1);
      want.row        = level[ROW_W-1:0];
      want.frame_last = (rw == ht + 1 && col == wd);
      expected_heat.push_back(want);
    end
    // commit the held pixel one column late
    if (col >= 1) shift_column(col - 1, held_pixel);
    held_pixel = item.old_pixel;
    if (col >= wd + 1) begin
      shift_column(col, item.old_pixel);
      col_pos = 0;
      row_pos = (rw >= ht + 1) ? 0 : rw + 1;
    end else begin
      col_pos = col + 1;
    end
  endtask

  task automatic check_result(input result_t got);
    result_t want;
    if (expected_heat.size() == 0) begin
      flag_mismatch($sformatf("result with none outstanding: pixel %0d column %0d row %0d",
                              got.new_pixel, got.column, got.row));
      return;
    end
    want = expected_heat.pop_front();
    if (got.new_pixel !== want.new_pixel)
      flag_mismatch($sformatf("new_pixel at row %0d column %0d: got %0d, want %0d",
                              want.row, want.column, got.new_pixel, want.new_pixel));
    if (got.column !== want.column)
      flag_mismatch($sformatf("column at row %0d: got %0d, want %0d",
                              want.row, got.column, want.column));
    if (got.row !== want.row)
      flag_mismatch($sformatf("row at column %0d: got %0d, want %0d",
                              want.column, got.row, want.row));
    if (got.frame_last !== want.frame_last)
      flag_mismatch($sformatf("frame_last at row %0d column %0d: got %0d, want %0d",
                              want.row, want.column, got.frame_last, want.frame_last));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      foreach (line_below[i]) begin
        line_below[i]     = '0;
        line_two_below[i] = '0;
      end
      col_pos    = 0;
      row_pos    = 0;
      held_pixel = '0;
      width_reg  = WIDTH_RESET;
      height_reg = HEIGHT_RESET;
      expected_heat.delete();
    end else begin
      if (cfg_write) begin
        if (cfg_index == CFG_WINDOW_WIDTH) width_reg = cfg_data[WIDTH_REG_W-1:0];
        else if (cfg_index == CFG_WINDOW_HEIGHT) height_reg = cfg_data[HEIGHT_REG_W-1:0];
      end
      if (pixel_valid && pixel_ready) propagate_pixel(pixel);
      if (result_valid && result_ready) check_result(result);
    end
    pending_count = expected_heat.size();
  end

endmodule

>>> verif/tb_fire_effect_propagator.sv
// ----------------------------------------------------------------------------
// tb_fire_effect_propagator
// Drives frames of old pixels into the fire propagator under a range of window
// sizes, including out-of-range register values, truncated frames, restarts
// mid-row and size changes mid-frame, with random gaps on the pixel side and
// random stalls on the result side. The checker beside the block predicts and
// compares; this module makes the stimulus and gives the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_fire_effect_propagator;
  import fep_pkg::*;

  localparam int MAX_WIDTH      = 64;
  localparam int MAX_HEIGHT     = 128;
  localparam int DIRECTED_ITEMS = 25;
  localparam int RANDOM_ITEMS   = 1250;
  localparam int FORCED_PHASES  = 4;
  localparam int SETTLE_CYCLES  = 16;
  localparam int CYCLE_LIMIT    = 1000000;

  logic                   clk;
  logic                   rst;
  logic                   cfg_write;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  logic                   pixel_valid;
  logic                   pixel_ready;
  pixel_t                 pixel;
  logic                   result_valid;
  logic                   result_ready;
  result_t                result;
  int                     fail_count;
  int                     pending_count;
  int                     cycle_count = 0;
  int                     sent_count;
  int                     frame_w;
  int                     frame_h;
  bit                     src_quiet;
  bit                     snk_quiet;

  fire_effect_propagator #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .pixel_valid  (pixel_valid),
    .pixel_ready  (pixel_ready),
    .pixel        (pixel),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  fire_effect_propagator_checker #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_check (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .pixel_valid   (pixel_valid),
    .pixel_ready   (pixel_ready),
    .pixel         (pixel),
    .result_valid  (result_valid),
    .result_ready  (result_ready),
    .result        (result),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic int clamp_size(input int v, input int hi);
    return (v < 1) ? 1 : (v > hi) ? hi : v;
  endfunction

  function automatic logic [PIXEL_W-1:0] draw_old_pixel();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_pixel(input logic [PIXEL_W-1:0] value, input logic start);
    int gap;
    if ($urandom_range(0, 39) == 0) src_quiet = !src_quiet;
    gap = src_quiet ? 0 : $urandom_range(0, 19);
    if (gap != 0) begin
      pixel_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    pixel_valid <= 1'b1;
    pixel       <= {value, start};
    @(posedge clk);
    while (!pixel_ready) @(posedge clk);
    sent_count++;
    @(negedge clk);
  endtask

  task automatic stream_pixels(input int count, input logic lead_start);
    for (int i = 0; i < count && sent_count < DIRECTED_ITEMS + RANDOM_ITEMS; i++)
      send_pixel(draw_old_pixel(), (i == 0 && lead_start) || $urandom_range(0, 99) == 0);
  endtask

  // hold the source until every outstanding result has drained
  task automatic drain_results();
    pixel_valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic load_window(input logic [WIDTH_REG_W-1:0] wv,
                             input logic [HEIGHT_REG_W-1:0] hv);
    cfg_write <= 1'b1;
    cfg_index <= CFG_WINDOW_WIDTH;
    cfg_data  <= {1'($urandom_range(0, 1)), wv};
    @(negedge clk);
    cfg_index <= CFG_WINDOW_HEIGHT;
    cfg_data  <= hv;
    @(negedge clk);
    cfg_write <= 1'b0;
    frame_w = clamp_size(wv, MAX_WIDTH);
    frame_h = clamp_size(hv, MAX_HEIGHT);
  endtask

  task automatic pick_window(input int phase, output logic [WIDTH_REG_W-1:0] wv,
                             output logic [HEIGHT_REG_W-1:0] hv);
    case (phase)
      0: begin
        wv = 7'd64;
        hv = 8'd1;
      end
      1: begin
        wv = 7'd1;
        hv = 8'd128;
      end
      2: begin
        wv = 7'd127;
        hv = 8'd0;
      end
      3: begin
        wv = 7'd0;
        hv = 8'd255;
      end
      default: begin
        case ($urandom_range(0, 19))
          0: hv = 8'd0;
          1: hv = 8'($urandom_range(129, 255));
          2: hv = 8'd128;
          3: hv = 8'($urandom_range(7, 127));
          default: hv = 8'($urandom_range(1, 6));
        endcase
        // keep tall windows narrow and wide windows short
        if (clamp_size(hv, MAX_HEIGHT) > 6) begin
          wv = 7'($urandom_range(0, 1));
        end else begin
          case ($urandom_range(0, 19))
            0: wv = 7'd0;
            1: wv = 7'($urandom_range(65, 127));
            2: wv = 7'd64;
            3: wv = 7'($urandom_range(9, 63));
            default: wv = 7'($urandom_range(1, 8));
          endcase
          if (clamp_size(wv, MAX_WIDTH) > 16) hv = 8'($urandom_range(0, 2));
        end
      end
    endcase
  endtask

  initial begin : sink
    int stall;
    result_ready = 1'b0;
    snk_quiet    = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if ($urandom_range(0, 39) == 0) snk_quiet = !snk_quiet;
      stall = snk_quiet ? 0 : $urandom_range(0, 19);
      if (stall != 0) begin
        result_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      result_ready <= 1'b1;
      @(posedge clk);
      while (!result_valid) @(posedge clk);
      @(negedge clk);
    end
  end

  initial begin : stimulus
    logic [WIDTH_REG_W-1:0]  wv;
    logic [HEIGHT_REG_W-1:0] hv;
    int                      phase;
    int                      len;
    int                      cut;
    rst         = 1'b1;
    cfg_write   = 1'b0;
    cfg_index   = CFG_WINDOW_WIDTH;
    cfg_data    = '0;
    pixel_valid = 1'b0;
    pixel       = '0;
    sent_count  = 0;
    src_quiet   = 1'b0;
    frame_w     = 32;
    frame_h     = 128;
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // zero-sized window acts as one by one; full-scale pixels wrap the result
    load_window(7'd0, 8'd0);
    for (int i = 0; i < 9; i++) send_pixel(8'hFF, i == 0);
    // next frame follows on without a frame start
    for (int i = 0; i < 9; i++) send_pixel(i[0] ? 8'hFF : 8'h00, 1'b0);
    // restart mid-row
    for (int i = 0; i < 3; i++) send_pixel(8'(i * 85), i == 0);
    for (int i = 0; i < 4; i++) send_pixel(8'hFF - 8'(i), i == 0);

    phase = 0;
    while (sent_count < DIRECTED_ITEMS + RANDOM_ITEMS) begin
      drain_results();
      pick_window(phase, wv, hv);
      load_window(wv, hv);
      repeat ($urandom_range(1, 3)) begin
        len = (frame_w + 2) * (frame_h + 2);
        case ($urandom_range(0, 9))
          0: stream_pixels($urandom_range(1, len - 1), 1'b1);
          1: stream_pixels(len, 1'b0);
          2: begin
            // resize the window part-way through a frame
            cut = $urandom_range(1, len - 1);
            stream_pixels(cut, 1'b1);
            drain_results();
            pick_window(FORCED_PHASES, wv, hv);
            load_window(wv, hv);
            stream_pixels($urandom_range(1, (frame_w + 2) * (frame_h + 2)), 1'b0);
          end
          default: stream_pixels(len, 1'b1);
        endcase
      end
      phase++;
    end

    drain_results();
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
